### rtl/core/detector_grid_box_merge_unit_defines.svh
// ---------------------------------------------------------------------------
// detector grid box merge: assertion macros
// shared concurrent assertion forms used by the checker
// ---------------------------------------------------------------------------
`ifndef DETECTOR_GRID_BOX_MERGE_UNIT_DEFINES_SVH
`define DETECTOR_GRID_BOX_MERGE_UNIT_DEFINES_SVH

// same-cycle implication
`define DGBM_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("dgbm same-cycle check failed");

// next-cycle implication
`define DGBM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("dgbm next-cycle check failed");

`endif

### rtl/core/dgbm_pkg.sv
// ---------------------------------------------------------------------------
// dgbm_pkg
// types, constants and region helpers of the detector grid box merge block
// ---------------------------------------------------------------------------
package dgbm_pkg;

	localparam int GRID_W_DEF      = 9;
	localparam int GRID_H_DEF      = 9;
	localparam int MAX_BOXES_DEF   = 16;
	localparam int CELL_PIXELS_DEF = 8;

	localparam int COORD_W = 4;
	localparam int SIZE_W  = 5;
	localparam int EXT_W   = SIZE_W + 1;
	localparam int PIX_W   = 7;
	localparam int SCORE_W = 8;

	localparam logic signed [SCORE_W-1:0] THRESHOLD_RESET = 8'sd39;

	typedef struct packed {
		logic [COORD_W-1:0]        cell_x;
		logic [COORD_W-1:0]        cell_y;
		logic signed [SCORE_W-1:0] score;
		logic                      last_cell;
	} cell_t;

	typedef struct packed {
		logic                      box_valid;
		logic [PIX_W-1:0]          box_x;
		logic [PIX_W-1:0]          box_y;
		logic [PIX_W-1:0]          box_width;
		logic [PIX_W-1:0]          box_height;
		logic signed [SCORE_W-1:0] box_score;
		logic                      last_box;
	} box_t;

	// rectangle in grid units
	typedef struct packed {
		logic [COORD_W-1:0]        x;
		logic [COORD_W-1:0]        y;
		logic [SIZE_W-1:0]         w;
		logic [SIZE_W-1:0]         h;
		logic signed [SCORE_W-1:0] score;
	} region_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CSCAN,
		S_CCHK,
		S_FRAME,
		S_BNEXT,
		S_BLOAD,
		S_BSCAN,
		S_BCHK,
		S_OUT,
		S_OEMIT
	} state_t;

	typedef struct packed {
		logic latch_cell;
		logic clr_idx;
		logic inc_idx;
		logic cube_rd;
		logic cube_merge;
		logic cube_append;
		logic load_cur;
		logic clr_bidx;
		logic inc_bidx;
		logic box_rd;
		logic box_merge;
		logic box_append;
		logic emit;
		logic emit_empty;
		logic frame_done;
	} cmd_t;

	typedef struct packed {
		logic cell_ok;
		logic last;
		logic cube_hit;
		logic box_hit;
		logic cube_idx_end;
		logic cube_full;
		logic box_idx_end;
		logic box_full;
		logic box_none;
		logic out_last;
	} sts_t;

	// inclusive overlap: touching edges count
	function automatic logic region_touch(input region_t r, input region_t c);
		logic [EXT_W-1:0] r_xe, r_ye, c_xe, c_ye;
		r_xe = EXT_W'(r.x) + EXT_W'(r.w);
		r_ye = EXT_W'(r.y) + EXT_W'(r.h);
		c_xe = EXT_W'(c.x) + EXT_W'(c.w);
		c_ye = EXT_W'(c.y) + EXT_W'(c.h);
		return !(r_xe < EXT_W'(c.x) || r_ye < EXT_W'(c.y) ||
			EXT_W'(r.x) > c_xe || EXT_W'(r.y) > c_ye);
	endfunction

	function automatic region_t region_union(input region_t r, input region_t c);
		logic [EXT_W-1:0]   r_xe, r_ye, c_xe, c_ye, xe, ye;
		logic [COORD_W-1:0] nx, ny;
		region_t            u;
		r_xe = EXT_W'(r.x) + EXT_W'(r.w);
		r_ye = EXT_W'(r.y) + EXT_W'(r.h);
		c_xe = EXT_W'(c.x) + EXT_W'(c.w);
		c_ye = EXT_W'(c.y) + EXT_W'(c.h);
		nx   = (c.x < r.x) ? c.x : r.x;
		ny   = (c.y < r.y) ? c.y : r.y;
		xe   = (c_xe > r_xe) ? c_xe : r_xe;
		ye   = (c_ye > r_ye) ? c_ye : r_ye;
		u.x     = nx;
		u.y     = ny;
		u.w     = SIZE_W'(xe - EXT_W'(nx));
		u.h     = SIZE_W'(ye - EXT_W'(ny));
		u.score = (c.score > r.score) ? c.score : r.score;
		return u;
	endfunction

endpackage

### rtl/core/dgbm_ctrl.sv
// ---------------------------------------------------------------------------
// dgbm_ctrl
// sequencer: cell scan over the cube store, box pass, box readout
// ---------------------------------------------------------------------------
module dgbm_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  dgbm_pkg::sts_t sts,
	output dgbm_pkg::cmd_t cmd,
	output logic           busy
);

	dgbm_pkg::state_t state_q, state_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dgbm_pkg::S_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		unique case (state_q)
			dgbm_pkg::S_IDLE: begin
				if (start) state_next = dgbm_pkg::S_CSCAN;
			end
			dgbm_pkg::S_CSCAN: begin
				if (!sts.cell_ok || sts.cube_idx_end) state_next = dgbm_pkg::S_FRAME;
				else state_next = dgbm_pkg::S_CCHK;
			end
			dgbm_pkg::S_CCHK: begin
				if (sts.cube_hit) state_next = dgbm_pkg::S_FRAME;
				else state_next = dgbm_pkg::S_CSCAN;
			end
			dgbm_pkg::S_FRAME: begin
				if (sts.last) state_next = dgbm_pkg::S_BNEXT;
				else state_next = dgbm_pkg::S_IDLE;
			end
			dgbm_pkg::S_BNEXT: begin
				if (sts.cube_idx_end || sts.box_full) state_next = dgbm_pkg::S_OUT;
				else state_next = dgbm_pkg::S_BLOAD;
			end
			dgbm_pkg::S_BLOAD: begin
				state_next = dgbm_pkg::S_BSCAN;
			end
			dgbm_pkg::S_BSCAN: begin
				if (sts.box_idx_end) state_next = dgbm_pkg::S_BNEXT;
				else state_next = dgbm_pkg::S_BCHK;
			end
			dgbm_pkg::S_BCHK: begin
				if (sts.box_hit) state_next = dgbm_pkg::S_BNEXT;
				else state_next = dgbm_pkg::S_BSCAN;
			end
			dgbm_pkg::S_OUT: begin
				if (sts.box_none) state_next = dgbm_pkg::S_IDLE;
				else state_next = dgbm_pkg::S_OEMIT;
			end
			dgbm_pkg::S_OEMIT: begin
				if (sts.out_last) state_next = dgbm_pkg::S_IDLE;
				else state_next = dgbm_pkg::S_OUT;
			end
			default: state_next = dgbm_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		cmd  = '0;
		busy = (state_q != dgbm_pkg::S_IDLE);
		unique case (state_q)
			dgbm_pkg::S_IDLE: begin
				cmd.latch_cell = start;
				cmd.clr_idx    = start;
			end
			dgbm_pkg::S_CSCAN: begin
				if (sts.cell_ok) begin
					cmd.cube_rd     = !sts.cube_idx_end;
					// no match anywhere: new 1x1 cube while there is room
					cmd.cube_append = sts.cube_idx_end && !sts.cube_full;
				end
			end
			dgbm_pkg::S_CCHK: begin
				cmd.cube_merge = sts.cube_hit;
				cmd.inc_idx    = !sts.cube_hit;
			end
			dgbm_pkg::S_FRAME: begin
				cmd.clr_idx = sts.last;
			end
			dgbm_pkg::S_BNEXT: begin
				if (sts.cube_idx_end || sts.box_full) cmd.clr_bidx = 1'b1;
				else cmd.cube_rd = 1'b1;
			end
			dgbm_pkg::S_BLOAD: begin
				cmd.load_cur = 1'b1;
				cmd.clr_bidx = 1'b1;
			end
			dgbm_pkg::S_BSCAN: begin
				if (sts.box_idx_end) begin
					cmd.box_append = 1'b1;
					cmd.inc_idx    = 1'b1;
				end else begin
					cmd.box_rd = 1'b1;
				end
			end
			dgbm_pkg::S_BCHK: begin
				if (sts.box_hit) begin
					cmd.box_merge = 1'b1;
					cmd.inc_idx   = 1'b1;
				end else begin
					cmd.inc_bidx = 1'b1;
				end
			end
			dgbm_pkg::S_OUT: begin
				if (sts.box_none) begin
					cmd.emit_empty = 1'b1;
					cmd.frame_done = 1'b1;
				end else begin
					cmd.box_rd = 1'b1;
				end
			end
			dgbm_pkg::S_OEMIT: begin
				cmd.emit       = 1'b1;
				cmd.frame_done = sts.out_last;
				cmd.inc_bidx   = !sts.out_last;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

### rtl/core/dgbm_datapath.sv
// ---------------------------------------------------------------------------
// dgbm_datapath
// cube and box stores, scan indexes, threshold register, result register
// ---------------------------------------------------------------------------
module dgbm_datapath #(
	parameter int GRID_W      = dgbm_pkg::GRID_W_DEF,
	parameter int GRID_H      = dgbm_pkg::GRID_H_DEF,
	parameter int MAX_BOXES   = dgbm_pkg::MAX_BOXES_DEF,
	parameter int CELL_PIXELS = dgbm_pkg::CELL_PIXELS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  dgbm_pkg::cell_t                     grid_cell,
	input  logic                                cfg_we,
	input  logic signed [dgbm_pkg::SCORE_W-1:0] cfg_data,
	input  dgbm_pkg::cmd_t                      cmd,
	output dgbm_pkg::sts_t                      sts,
	output dgbm_pkg::box_t                      box,
	output logic                                box_strobe
);

	localparam int CUBE_CAP = GRID_W * GRID_H;
	localparam int CA_W     = (CUBE_CAP > 1) ? $clog2(CUBE_CAP) : 1;
	localparam int CC_W     = $clog2(CUBE_CAP + 1);
	localparam int BA_W     = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
	localparam int BC_W     = $clog2(MAX_BOXES + 1);
	localparam int PROD_W   = dgbm_pkg::SIZE_W + $clog2(CELL_PIXELS + 1);

	dgbm_pkg::region_t cube_mem [CUBE_CAP];
	dgbm_pkg::region_t box_mem  [MAX_BOXES];

	logic signed [dgbm_pkg::SCORE_W-1:0] thr_q;
	dgbm_pkg::region_t cur_q, cube_rdata_q, box_rdata_q;
	dgbm_pkg::region_t cube_wdata, box_wdata;
	logic              cell_ok_q, last_q;
	logic [CC_W-1:0]   cube_count_q, idx_q;
	logic [BC_W-1:0]   box_count_q, bidx_q, bidx_inc;
	logic [CA_W-1:0]   cube_waddr;
	logic [BA_W-1:0]   box_waddr;
	logic              cube_we, box_we;
	dgbm_pkg::box_t    box_q;
	logic              strobe_q;
	logic              in_grid;

	function automatic logic [dgbm_pkg::PIX_W-1:0] to_pixels(
		input logic [dgbm_pkg::SIZE_W-1:0] v
	);
		logic [PROD_W-1:0] p;
		p = PROD_W'(v) * PROD_W'(CELL_PIXELS);
		return p[dgbm_pkg::PIX_W-1:0];
	endfunction

	assign in_grid = (5'(grid_cell.cell_x) < 5'(GRID_W))
		&& (5'(grid_cell.cell_y) < 5'(GRID_H));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= dgbm_pkg::THRESHOLD_RESET;
		end else if (cfg_we) begin
			thr_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_ok_q <= 1'b0;
			last_q    <= 1'b0;
		end else if (cmd.latch_cell) begin
			cell_ok_q <= in_grid && (grid_cell.score >= thr_q);
			last_q    <= grid_cell.last_cell;
		end
	end

	// working region: the incoming cell, later the cube being placed
	always_ff @(posedge clk) begin
		if (cmd.latch_cell) begin
			cur_q.x     <= grid_cell.cell_x;
			cur_q.y     <= grid_cell.cell_y;
			cur_q.w     <= dgbm_pkg::SIZE_W'(1);
			cur_q.h     <= dgbm_pkg::SIZE_W'(1);
			cur_q.score <= grid_cell.score;
		end else if (cmd.load_cur) begin
			cur_q <= cube_rdata_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q        <= '0;
			bidx_q       <= '0;
			cube_count_q <= '0;
			box_count_q  <= '0;
		end else begin
			if (cmd.clr_idx) idx_q <= '0;
			else if (cmd.inc_idx) idx_q <= idx_q + 1'b1;
			if (cmd.clr_bidx) bidx_q <= '0;
			else if (cmd.inc_bidx) bidx_q <= bidx_inc;
			if (cmd.frame_done) begin
				cube_count_q <= '0;
				box_count_q  <= '0;
			end else begin
				if (cmd.cube_append) cube_count_q <= cube_count_q + 1'b1;
				if (cmd.box_append) box_count_q <= box_count_q + 1'b1;
			end
		end
	end

	assign bidx_inc = bidx_q + 1'b1;

	assign cube_we    = cmd.cube_merge || cmd.cube_append;
	assign cube_waddr = cmd.cube_append ? cube_count_q[CA_W-1:0] : idx_q[CA_W-1:0];
	assign cube_wdata = cmd.cube_append ? cur_q
		: dgbm_pkg::region_union(cube_rdata_q, cur_q);

	assign box_we    = cmd.box_merge || cmd.box_append;
	assign box_waddr = cmd.box_append ? box_count_q[BA_W-1:0] : bidx_q[BA_W-1:0];
	assign box_wdata = cmd.box_append ? cur_q
		: dgbm_pkg::region_union(box_rdata_q, cur_q);

	always_ff @(posedge clk) begin
		if (cube_we) cube_mem[cube_waddr] <= cube_wdata;
		if (cmd.cube_rd) cube_rdata_q <= cube_mem[idx_q[CA_W-1:0]];
	end

	always_ff @(posedge clk) begin
		if (box_we) box_mem[box_waddr] <= box_wdata;
		if (cmd.box_rd) box_rdata_q <= box_mem[bidx_q[BA_W-1:0]];
	end

	always_comb begin
		sts              = '0;
		sts.cell_ok      = cell_ok_q;
		sts.last         = last_q;
		sts.cube_hit     = dgbm_pkg::region_touch(cube_rdata_q, cur_q);
		sts.box_hit      = dgbm_pkg::region_touch(box_rdata_q, cur_q);
		sts.cube_idx_end = (idx_q == cube_count_q);
		sts.cube_full    = (cube_count_q == CC_W'(CUBE_CAP));
		sts.box_idx_end  = (bidx_q == box_count_q);
		sts.box_full     = (box_count_q == BC_W'(MAX_BOXES));
		sts.box_none     = (box_count_q == '0);
		sts.out_last     = (bidx_inc == box_count_q);
	end

	// one-cycle result transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= cmd.emit || cmd.emit_empty;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_empty) begin
			box_q <= '{last_box: 1'b1, default: '0};
		end else if (cmd.emit) begin
			box_q.box_valid  <= 1'b1;
			box_q.box_x      <= to_pixels(dgbm_pkg::SIZE_W'(box_rdata_q.x));
			box_q.box_y      <= to_pixels(dgbm_pkg::SIZE_W'(box_rdata_q.y));
			box_q.box_width  <= to_pixels(box_rdata_q.w);
			box_q.box_height <= to_pixels(box_rdata_q.h);
			box_q.box_score  <= box_rdata_q.score;
			box_q.last_box   <= sts.out_last;
		end
	end

	assign box        = box_q;
	assign box_strobe = strobe_q;

endmodule

### rtl/core/detector_grid_box_merge_unit.sv
// ---------------------------------------------------------------------------
// detector_grid_box_merge_unit
// grid detector cell decode and box merge, one class
// ---------------------------------------------------------------------------
// A cell is taken at a clock edge with start high and busy low. Cells below
// threshold_code or outside the grid are dropped; others merge into the first
// stored cube they touch, else open a new 1x1 cube.
// Per kept cell, the stored cubes are read from the cube store one at a time
// and compared up to the first match; no new cell is taken before that scan ends.
// On a cell with last_cell set, the box pass follows: each cube taken is
// compared with the boxes in turn and merges into the first one it touches,
// else opens a new box, until the box store is full. Then each box is read
// in turn and shown for one cycle on box with box_strobe, in store order;
// an empty frame gives one result with box_valid low. last_box marks the end.
// The receiver cannot stall: each result is there for exactly one cycle.
// threshold_code is written over cfg_valid/cfg_ready; cfg_ready is low while
// busy. Reset clears the counts and loads threshold_code 39; the stores need
// no clearing since only entries below the counts are ever read.
// ---------------------------------------------------------------------------
module detector_grid_box_merge_unit #(
	parameter int GRID_W      = dgbm_pkg::GRID_W_DEF,
	parameter int GRID_H      = dgbm_pkg::GRID_H_DEF,
	parameter int MAX_BOXES   = dgbm_pkg::MAX_BOXES_DEF,
	parameter int CELL_PIXELS = dgbm_pkg::CELL_PIXELS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  dgbm_pkg::cell_t                     grid_cell,
	output dgbm_pkg::box_t                      box,
	output logic                                box_strobe,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic signed [dgbm_pkg::SCORE_W-1:0] cfg_data
);

	dgbm_pkg::cmd_t cmd;
	dgbm_pkg::sts_t sts;

	assign cfg_ready = !busy;

	dgbm_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	dgbm_datapath #(
		.GRID_W      (GRID_W),
		.GRID_H      (GRID_H),
		.MAX_BOXES   (MAX_BOXES),
		.CELL_PIXELS (CELL_PIXELS)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.grid_cell  (grid_cell),
		.cfg_we     (cfg_valid && cfg_ready),
		.cfg_data   (cfg_data),
		.cmd        (cmd),
		.sts        (sts),
		.box        (box),
		.box_strobe (box_strobe)
	);

endmodule

### rtl/core/dgbm_checker.sv
// ---------------------------------------------------------------------------
// dgbm_checker
// port-level checks on result framing of the box merge unit
// ---------------------------------------------------------------------------
`include "detector_grid_box_merge_unit_defines.svh"

module dgbm_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           start,
	input logic           busy,
	input dgbm_pkg::box_t box,
	input logic           box_strobe
);

	// frame ends with one result and a gap
	`DGBM_ASSERT_NEXT(a_last_then_gap, clk, arst_n, box_strobe && box.last_box, !box_strobe)

	// more results pending keeps the unit busy
	`DGBM_ASSERT_SAME(a_mid_frame_busy, clk, arst_n, box_strobe && !box.last_box, busy)

	// empty frame result is all zero and final
	`DGBM_ASSERT_SAME(a_empty_result, clk, arst_n, box_strobe && !box.box_valid, box.last_box && box.box_x == 0 && box.box_y == 0 && box.box_width == 0 && box.box_height == 0 && box.box_score == 0)

	// no result right after a cell transfer
	`DGBM_ASSERT_NEXT(a_no_early_result, clk, arst_n, start && !busy, !box_strobe)

endmodule

bind detector_grid_box_merge_unit dgbm_checker u_dgbm_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.start      (start),
	.busy       (busy),
	.box        (box),
	.box_strobe (box_strobe)
);

### tb/tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb: detector grid box merge unit testbench
// drives grid cells and threshold writes, predicts the merged boxes of each
// frame and compares every strobed box against that prediction in order
// ---------------------------------------------------------------------------
module tb;

	localparam int LIMIT_CYCLES = 1000000;
	localparam int SETTLE       = 200;
	localparam int ITEMS        = 120;

	// predicts the boxes of each frame and holds those not yet seen
	class box_tracker;
		logic signed [dgbm_pkg::SCORE_W-1:0] thr;
		dgbm_pkg::region_t                   cubes[$];
		dgbm_pkg::box_t                      pending_boxes[$];
		int                                  bad_boxes;
		int                                  boxes_seen;

		function new();
			thr        = dgbm_pkg::THRESHOLD_RESET;
			bad_boxes  = 0;
			boxes_seen = 0;
		endfunction

		// inclusive touch test, grows r to the union on a hit
		function bit absorb(inout dgbm_pkg::region_t r, input dgbm_pkg::region_t c);
			int rx, ry, rxe, rye, cx, cy, cxe, cye, nx, ny, xe, ye;
			rx  = int'(r.x);
			ry  = int'(r.y);
			rxe = rx + int'(r.w);
			rye = ry + int'(r.h);
			cx  = int'(c.x);
			cy  = int'(c.y);
			cxe = cx + int'(c.w);
			cye = cy + int'(c.h);
			if (rxe < cx || rye < cy || rx > cxe || ry > cye)
				return 1'b0;
			nx = (cx < rx) ? cx : rx;
			ny = (cy < ry) ? cy : ry;
			xe = (cxe > rxe) ? cxe : rxe;
			ye = (cye > rye) ? cye : rye;
			r.x = dgbm_pkg::COORD_W'(nx);
			r.y = dgbm_pkg::COORD_W'(ny);
			r.w = dgbm_pkg::SIZE_W'(xe - nx);
			r.h = dgbm_pkg::SIZE_W'(ye - ny);
			if (c.score > r.score)
				r.score = c.score;
			return 1'b1;
		endfunction

		function void take_cell(dgbm_pkg::cell_t c);
			dgbm_pkg::region_t n, tmp;
			dgbm_pkg::region_t boxes[$];
			dgbm_pkg::box_t    o;
			bit                hit;
			if (c.cell_x < dgbm_pkg::GRID_W_DEF && c.cell_y < dgbm_pkg::GRID_H_DEF
				&& c.score >= thr) begin
				n.x     = c.cell_x;
				n.y     = c.cell_y;
				n.w     = dgbm_pkg::SIZE_W'(1);
				n.h     = dgbm_pkg::SIZE_W'(1);
				n.score = c.score;
				hit     = 1'b0;
				for (int i = 0; i < cubes.size() && !hit; i++) begin
					tmp = cubes[i];
					if (absorb(tmp, n)) begin
						cubes[i] = tmp;
						hit = 1'b1;
					end
				end
				if (!hit && cubes.size() < dgbm_pkg::GRID_W_DEF * dgbm_pkg::GRID_H_DEF)
					cubes.push_back(n);
			end
			if (!c.last_cell)
				return;
			// second pass: cubes into boxes, later cubes dropped at the box limit
			for (int i = 0; i < cubes.size() && boxes.size() < dgbm_pkg::MAX_BOXES_DEF;
				i++) begin
				hit = 1'b0;
				for (int b = 0; b < boxes.size() && !hit; b++) begin
					tmp = boxes[b];
					if (absorb(tmp, cubes[i])) begin
						boxes[b] = tmp;
						hit = 1'b1;
					end
				end
				if (!hit)
					boxes.push_back(cubes[i]);
			end
			if (boxes.size() == 0) begin
				o = '0;
				o.last_box = 1'b1;
				pending_boxes.push_back(o);
			end else begin
				foreach (boxes[k]) begin
					o.box_valid  = 1'b1;
					o.box_x      = dgbm_pkg::PIX_W'(int'(boxes[k].x) * dgbm_pkg::CELL_PIXELS_DEF);
					o.box_y      = dgbm_pkg::PIX_W'(int'(boxes[k].y) * dgbm_pkg::CELL_PIXELS_DEF);
					o.box_width  = dgbm_pkg::PIX_W'(int'(boxes[k].w) * dgbm_pkg::CELL_PIXELS_DEF);
					o.box_height = dgbm_pkg::PIX_W'(int'(boxes[k].h) * dgbm_pkg::CELL_PIXELS_DEF);
					o.box_score  = boxes[k].score;
					o.last_box   = (k == boxes.size() - 1);
					pending_boxes.push_back(o);
				end
			end
			cubes.delete();
		endfunction

		function string show(dgbm_pkg::box_t b);
			return $sformatf("valid=%0d x=%0d y=%0d w=%0d h=%0d score=%0d last=%0d",
				b.box_valid, b.box_x, b.box_y, b.box_width, b.box_height,
				b.box_score, b.last_box);
		endfunction

		function void flag(string msg);
			bad_boxes++;
			if (bad_boxes <= 10)
				$display("[%0t] %s", $time, msg);
		endfunction

		function void check_box(dgbm_pkg::box_t got);
			dgbm_pkg::box_t want;
			boxes_seen++;
			if (pending_boxes.size() == 0) begin
				flag($sformatf("unexpected box: %s", show(got)));
				return;
			end
			want = pending_boxes.pop_front();
			if (got.box_valid !== want.box_valid || got.box_x !== want.box_x ||
				got.box_y !== want.box_y || got.box_width !== want.box_width ||
				got.box_height !== want.box_height || got.box_score !== want.box_score ||
				got.last_box !== want.last_box)
				flag($sformatf("box mismatch: expected %s, got %s", show(want), show(got)));
		endfunction
	endclass

	logic                                clk;
	logic                                arst_n;
	logic                                start;
	logic                                busy;
	dgbm_pkg::cell_t                     grid_cell;
	dgbm_pkg::box_t                      box;
	logic                                box_strobe;
	logic                                cfg_valid;
	logic                                cfg_ready;
	logic signed [dgbm_pkg::SCORE_W-1:0] cfg_data;
	int                                  cycle_count;
	int                                  sent_count;

	box_tracker tracker = new();

	detector_grid_box_merge_unit u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.grid_cell  (grid_cell),
		.box        (box),
		.box_strobe (box_strobe),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// every transfer is seen here, on pre-edge values
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				tracker.thr = cfg_data;
			if (start && !busy)
				tracker.take_cell(grid_cell);
			if (box_strobe)
				tracker.check_box(box);
		end
	end

	function automatic dgbm_pkg::cell_t mk(int x, int y, int s, bit last);
		dgbm_pkg::cell_t c;
		c.cell_x    = dgbm_pkg::COORD_W'(x);
		c.cell_y    = dgbm_pkg::COORD_W'(y);
		c.score     = dgbm_pkg::SCORE_W'(s);
		c.last_cell = last;
		return c;
	endfunction

	function automatic int score_from(int lo);
		return lo + int'($urandom_range(0, 127 - lo));
	endfunction

	// start stays high across back-to-back cells
	task automatic send_cell(input dgbm_pkg::cell_t c, input int gap);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start     <= 1'b1;
		grid_cell <= c;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		sent_count++;
	endtask

	task automatic drain();
		start <= 1'b0;
		while (tracker.pending_boxes.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_threshold(input logic signed [dgbm_pkg::SCORE_W-1:0] v);
		drain();
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic run_directed();
		dgbm_pkg::cell_t dq[$];
		// two separate cubes, threshold edge, off-grid last cell
		dq.push_back(mk(0, 0, 127, 0));
		dq.push_back(mk(8, 8, 39, 0));
		dq.push_back(mk(15, 15, 127, 1));
		// only cell below threshold: empty frame
		dq.push_back(mk(3, 3, -128, 1));
		// cube grows into its neighbor, the two merge in the box pass
		dq.push_back(mk(0, 0, 80, 0));
		dq.push_back(mk(2, 0, 90, 0));
		dq.push_back(mk(1, 0, 50, 0));
		dq.push_back(mk(4, 4, 39, 1));
		// 17 isolated cells: box limit reached, last cube dropped
		for (int i = 0; i < 17; i++)
			dq.push_back(mk(2 * (i % 5), 2 * (i / 5), 40 + i, i == 16));
		foreach (dq[i])
			send_cell(dq[i], $urandom_range(0, 12));
	endtask

	task automatic run_random();
		dgbm_pkg::cell_t                     frame[$];
		dgbm_pkg::cell_t                     t;
		logic signed [dgbm_pkg::SCORE_W-1:0] thr;
		int                                  phase, gap_max, kind, n, j;
		int                                  ccx, ccy, cx, cy, s, cur;
		phase = 0;
		while (sent_count < ITEMS) begin
			case (phase)
				0: thr = -8'sd128;
				1: thr = 8'sd127;
				default: thr = $signed(8'($urandom_range(0, 255)));
			endcase
			cur     = int'(thr);
			gap_max = (phase % 3 == 1) ? 0 : 12;
			write_threshold(thr);
			repeat ($urandom_range(2, 5)) begin
				if (sent_count >= ITEMS)
					break;
				frame.delete();
				kind = $urandom_range(0, 9);
				if (kind < 7) begin
					// clustered cells around moving centers
					ccx = $urandom_range(0, 8);
					ccy = $urandom_range(0, 8);
					n   = $urandom_range(1, 10);
					for (int i = 0; i < n; i++) begin
						if ($urandom_range(0, 3) == 0) begin
							ccx = $urandom_range(0, 8);
							ccy = $urandom_range(0, 8);
						end
						cx = ccx + int'($urandom_range(0, 2)) - 1;
						cy = ccy + int'($urandom_range(0, 2)) - 1;
						cx = (cx < 0) ? 0 : (cx > 8) ? 8 : cx;
						cy = (cy < 0) ? 0 : (cy > 8) ? 8 : cy;
						if ($urandom_range(0, 11) == 0)
							cx = $urandom_range(9, 15);
						s = ($urandom_range(0, 4) == 0) ? int'($urandom_range(0, 255)) - 128
							: score_from(cur);
						frame.push_back(mk(cx, cy, s, 0));
					end
					frame[frame.size() - 1].last_cell = 1'b1;
				end else if (kind == 7) begin
					// isolated cells in shuffled order, past the box limit
					for (int i = 0; i < 25; i++)
						frame.push_back(mk(2 * (i % 5), 2 * (i / 5), score_from(cur), 0));
					for (int i = 24; i > 0; i--) begin
						j        = $urandom_range(0, i);
						t        = frame[i];
						frame[i] = frame[j];
						frame[j] = t;
					end
					n = $urandom_range(17, 25);
					while (frame.size() > n)
						void'(frame.pop_back());
					frame[frame.size() - 1].last_cell = 1'b1;
				end else begin
					// noise: any coordinates, any score, frame ends anywhere
					n = $urandom_range(1, 6);
					for (int i = 0; i < n; i++)
						frame.push_back(mk($urandom_range(0, 15), $urandom_range(0, 15),
							int'($urandom_range(0, 255)) - 128, $urandom_range(0, 3) == 0));
				end
				foreach (frame[i])
					send_cell(frame[i], gap_max ? $urandom_range(0, gap_max) : 0);
			end
			phase++;
		end
	endtask

	initial begin
		sent_count = 0;
		start     <= 1'b0;
		grid_cell <= '0;
		cfg_valid <= 1'b0;
		cfg_data  <= '0;
		arst_n    <= 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		run_directed();
		run_random();
		drain();
		if (tracker.pending_boxes.size() != 0)
			tracker.flag($sformatf("%0d expected boxes never arrived",
				tracker.pending_boxes.size()));
		if (tracker.bad_boxes == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < LIMIT_CYCLES) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Regression FAIL");
		$finish;
	end

endmodule

### filelist.f
+incdir+rtl/core
rtl/core/dgbm_pkg.sv
rtl/core/dgbm_ctrl.sv
rtl/core/dgbm_datapath.sv
rtl/core/detector_grid_box_merge_unit.sv
rtl/core/dgbm_checker.sv
tb/tb.sv
